// ===== design/frt_pkg.sv =====
// shared types and constants for the fragment reassembly tracker
// no dependencies; imported by frt_tracker and fragment_reassembly_tracker_core
package frt_pkg;

  localparam int MAX_FRAGMENTS       = 128;
  localparam int MAX_FRAGMENT_LENGTH = 16383;

  localparam int INDEX_W  = 7;
  localparam int LENGTH_W = 14;
  localparam int TOTAL_W  = 21;
  localparam int SPAN_W   = 8;
  localparam int STATUS_W = 2;
  localparam int MAP_DEPTH = 1 << INDEX_W;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic [STATUS_W-1:0] ST_ACCEPTED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BEYOND_LAST = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                complete;
    logic [TOTAL_W-1:0]  byte_total;
    logic [SPAN_W-1:0]   span;
  } frt_result_t;

endpackage

// ===== design/frt_tracker.sv =====
// message state of the tracker: received map, span, count, byte total
// one fragment is checked and recorded per step; depends on frt_pkg
module frt_tracker import frt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [INDEX_W-1:0]  frag_index,
  input  logic [LENGTH_W-1:0] frag_length,
  input  logic                is_last,
  output frt_result_t         result
);

  logic [MAP_DEPTH-1:0] received_map;
  logic                 last_seen;
  logic [INDEX_W-1:0]   last_index;
  logic [SPAN_W-1:0]    slot_span;
  logic [SPAN_W-1:0]    received_count;
  logic [TOTAL_W-1:0]   total_bytes;

  logic                 last_seen_next;
  logic [INDEX_W-1:0]   last_index_next;
  logic [SPAN_W-1:0]    slot_span_next;
  logic [SPAN_W-1:0]    received_count_next;
  logic [TOTAL_W-1:0]   total_bytes_next;

  logic                 beyond;
  logic                 dup;
  logic                 take;
  logic [SPAN_W-1:0]    index_plus;
  logic [LENGTH_W-1:0]  len_clamped;
  logic [TOTAL_W:0]     sum;

  always_comb begin
    beyond = (9'(frag_index) >= 9'(MAX_FRAGMENTS)) ||
             (last_seen && (frag_index > last_index));
    dup    = received_map[frag_index];
    take   = !beyond && !dup;

    index_plus  = SPAN_W'(frag_index) + SPAN_W'(1);
    len_clamped = (17'(frag_length) > 17'(MAX_FRAGMENT_LENGTH)) ?
                  LENGTH_W'(MAX_FRAGMENT_LENGTH) : frag_length;
    // one guard bit catches overflow for saturation
    sum = (TOTAL_W+1)'(total_bytes) + (TOTAL_W+1)'(len_clamped);

    last_seen_next      = last_seen;
    last_index_next     = last_index;
    slot_span_next      = slot_span;
    received_count_next = received_count;
    total_bytes_next    = total_bytes;
    if (take) begin
      if (is_last) begin
        last_seen_next  = 1'b1;
        last_index_next = frag_index;
      end
      if (slot_span < index_plus) begin
        slot_span_next = index_plus;
      end
      received_count_next = received_count + SPAN_W'(1);
      total_bytes_next    = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    end

    if (beyond) begin
      result.status = ST_BEYOND_LAST;
    end else if (dup) begin
      result.status = ST_DUPLICATE;
    end else begin
      result.status = ST_ACCEPTED;
    end
    result.complete   = last_seen_next && (received_count_next == slot_span_next);
    result.byte_total = total_bytes_next;
    result.span       = slot_span_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      received_map   <= '0;
      last_seen      <= 1'b0;
      last_index     <= '0;
      slot_span      <= '0;
      received_count <= '0;
      total_bytes    <= '0;
    end else if (step) begin
      if (take) begin
        received_map[frag_index] <= 1'b1;
      end
      last_seen      <= last_seen_next;
      last_index     <= last_index_next;
      slot_span      <= slot_span_next;
      received_count <= received_count_next;
      total_bytes    <= total_bytes_next;
    end
  end

  // every received slot lies below the span
  a_count_within_span: assert property (@(posedge clk) disable iff (rst)
    received_count <= slot_span)
    else $error("received count exceeds span");

  // state only moves on a step
  a_idle_holds_total: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(total_bytes) && $stable(received_count))
    else $error("tracker state changed without a step");

  // an accepted fragment always lands in the map
  a_accept_marks_map: assert property (@(posedge clk) disable iff (rst)
    step && take |=> received_map[$past(frag_index)])
    else $error("accepted fragment not marked received");

endmodule

// ===== design/fragment_reassembly_tracker_core.sv =====
// top level of the fragment reassembly tracker: input register, tracker, result register
// depends on frt_pkg and frt_tracker
//
// usage:
//   frag channel (frag_valid / frag_stall) carries one fragment per beat:
//   frag_index, frag_length and is_last. a beat is taken on a rising edge
//   with frag_valid high and frag_stall low.
//   result channel (result_valid / result_stall) carries one result beat per
//   fragment, in order: status, complete, byte_total and span.
//   a fragment taken into the input register shows its result from the result register.
//   throughput: one fragment per cycle unless result_stall holds a result; the received-map
//   read, update and counters all sit between the input register and the result register.
//   stall: a result held by result_stall stays put; one more fragment can still
//   be taken into the input register, after which frag_stall rises until the
//   result beat drains.
//   reset (rst, synchronous): empties both registers, clears the received map,
//   span, count, last flag and byte total, so a new message starts.
module fragment_reassembly_tracker_core import frt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                frag_valid,
  output logic                frag_stall,
  input  logic [INDEX_W-1:0]  frag_index,
  input  logic [LENGTH_W-1:0] frag_length,
  input  logic                is_last,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [STATUS_W-1:0] status,
  output logic                complete,
  output logic [TOTAL_W-1:0]  byte_total,
  output logic [SPAN_W-1:0]   span
);

  // input register
  logic                s1_valid;
  logic [INDEX_W-1:0]  s1_index;
  logic [LENGTH_W-1:0] s1_length;
  logic                s1_last;

  logic        advance;
  logic        step;
  frt_result_t step_result;

  // result register is free when empty or drained this cycle
  assign advance    = !result_valid || !result_stall;
  assign step       = s1_valid && advance;
  assign frag_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!frag_stall) begin
      s1_valid <= frag_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frag_valid && !frag_stall) begin
      s1_index  <= frag_index;
      s1_length <= frag_length;
      s1_last   <= is_last;
    end
  end

  // bitmap check and update for the fragment in the input register
  frt_tracker u_tracker (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .frag_index  (s1_index),
    .frag_length (s1_length),
    .is_last     (s1_last),
    .result      (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      status     <= step_result.status;
      complete   <= step_result.complete;
      byte_total <= step_result.byte_total;
      span       <= step_result.span;
    end
  end

  // back-pressure only when a fragment is actually waiting
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    frag_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  // an accepted fragment always covers at least one slot
  a_accept_has_span: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_ACCEPTED) |-> (span != '0))
    else $error("accepted result with zero span");

  // a completed message has a nonzero span
  a_complete_has_span: assert property (@(posedge clk) disable iff (rst)
    result_valid && complete |-> (span != '0))
    else $error("complete reported with zero span");

  // a fragment in the input register moves to the result register once it is free
  a_item_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance |=> result_valid)
    else $error("fragment lost between registers");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for fragment_reassembly_tracker_core: fragment beats in, report beats out
// predicts every report from its own copy of the tracker state; needs frt_pkg and the design

module testbench import frt_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
  localparam int RANDOM_BEATS   = 1730;
  localparam int CALM_BEATS     = 200;   // tail of the run with no idling at all
  localparam int SQUEEZE_AT     = 400;   // random beat at which the long hold-off starts
  localparam int SQUEEZE_CYCLES = 80;
  localparam int DRAIN_CYCLES   = 8;
  localparam int REPORT_LIMIT   = 10;
  localparam int SCRIPT_ROWS    = 16;

  localparam logic [LENGTH_W-1:0] LEN_MAX = LENGTH_W'(MAX_FRAGMENT_LENGTH);

  // one row of the directed script; rep is used only when typed is set
  typedef struct packed {
    logic [INDEX_W-1:0]  idx;
    logic [LENGTH_W-1:0] len;
    logic                last;
    logic                typed;
    frt_result_t         rep;
  } script_row_t;

  localparam frt_result_t NO_REPORT = '0;

  logic                clk;
  logic                rst;
  logic                frag_valid;
  logic                frag_stall;
  logic [INDEX_W-1:0]  frag_index;
  logic [LENGTH_W-1:0] frag_length;
  logic                is_last;
  logic                result_valid;
  logic                result_stall;
  logic [STATUS_W-1:0] status;
  logic                complete;
  logic [TOTAL_W-1:0]  byte_total;
  logic [SPAN_W-1:0]   span;

  fragment_reassembly_tracker_core uut (
    .clk          (clk),
    .rst          (rst),
    .frag_valid   (frag_valid),
    .frag_stall   (frag_stall),
    .frag_index   (frag_index),
    .frag_length  (frag_length),
    .is_last      (is_last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .complete     (complete),
    .byte_total   (byte_total),
    .span         (span)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // tracker state mirrored on the bench side, updated on every accepted fragment beat
  bit                  seen_map [MAP_DEPTH];
  bit                  last_known   = 1'b0;
  logic [INDEX_W-1:0]  last_slot    = '0;
  logic [SPAN_W-1:0]   span_now     = '0;
  logic [SPAN_W-1:0]   seen_count   = '0;
  logic [TOTAL_W-1:0]  bytes_so_far = '0;

  // reports still owed by the block, oldest first
  frt_result_t pending_reports [$];

  // a typed-in report rides along with the fragment beat that causes it
  logic        typed_valid;
  frt_result_t typed_report;

  int mismatches  = 0;
  int idle_cycles = 0;
  bit calm        = 1'b0;
  bit squeeze_req = 1'b0;
  bit squeeze_on  = 1'b0;

  // directed script: first rows are typed in, the rest go through the predictor
  script_row_t script [SCRIPT_ROWS] = '{
    // first fragment of the message, zero length
    '{7'd0,   14'd0,      1'b0, 1'b1, '{ST_ACCEPTED,  1'b0, 21'd0,     8'd1}},
    // same slot again, last flag on a duplicate has no effect
    '{7'd0,   14'd16383,  1'b1, 1'b1, '{ST_DUPLICATE, 1'b0, 21'd0,     8'd1}},
    // top slot, full length, marks the last index at the top
    '{7'd127, 14'd16383,  1'b1, 1'b1, '{ST_ACCEPTED,  1'b0, 21'd16383, 8'd128}},
    '{7'd127, 14'd0,      1'b0, 1'b1, '{ST_DUPLICATE, 1'b0, 21'd16383, 8'd128}},
    '{7'd85,  14'h2AAA,   1'b0, 1'b0, NO_REPORT},
    '{7'd42,  14'h1555,   1'b0, 1'b0, NO_REPORT},
    '{7'd126, 14'd16383,  1'b0, 1'b0, NO_REPORT},
    '{7'd1,   14'h3FFE,   1'b0, 1'b0, NO_REPORT},
    '{7'd42,  14'd16383,  1'b1, 1'b0, NO_REPORT},
    // a second last flag pulls the last index down below slots already taken
    '{7'd125, 14'd1,      1'b1, 1'b0, NO_REPORT},
    // received and beyond last: beyond-last wins over duplicate
    '{7'd126, 14'd0,      1'b0, 1'b0, NO_REPORT},
    '{7'd127, 14'd16383,  1'b0, 1'b0, NO_REPORT},
    '{7'd124, 14'd8191,   1'b0, 1'b0, NO_REPORT},
    '{7'd64,  14'd0,      1'b0, 1'b0, NO_REPORT},
    '{7'd63,  14'd16383,  1'b0, 1'b0, NO_REPORT},
    '{7'd125, 14'd5,      1'b0, 1'b0, NO_REPORT}
  };

  // next state and report of the tracker for one fragment beat
  function automatic frt_result_t track_fragment(input logic [INDEX_W-1:0]  idx,
                                                 input logic [LENGTH_W-1:0] len,
                                                 input logic                last);
    frt_result_t         r;
    logic [LENGTH_W-1:0] clipped;
    logic [TOTAL_W:0]    sum;
    logic [SPAN_W-1:0]   reach;
    reach = {1'b0, idx} + 8'd1;
    if (int'(idx) >= MAX_FRAGMENTS || (last_known && idx > last_slot)) begin
      r.status = ST_BEYOND_LAST;
    end else if (seen_map[idx]) begin
      r.status = ST_DUPLICATE;
    end else begin
      r.status = ST_ACCEPTED;
      if (last) begin
        last_known = 1'b1;
        last_slot  = idx;
      end
      if (span_now < reach) span_now = reach;
      seen_map[idx] = 1'b1;
      seen_count    = seen_count + 8'd1;
      clipped = (len > LEN_MAX) ? LEN_MAX : len;
      sum = {1'b0, bytes_so_far} + (TOTAL_W+1)'(clipped);
      bytes_so_far = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    end
    r.complete   = last_known && (seen_count == span_now);
    r.byte_total = bytes_so_far;
    r.span       = span_now;
    return r;
  endfunction

  // highest slot not yet received, -1 once the map is full
  function automatic int top_open_slot();
    for (int s = MAP_DEPTH - 1; s >= 0; s--) begin
      if (!seen_map[s]) return s;
    end
    return -1;
  endfunction

  task automatic flag_mismatch(input string what, input frt_result_t want,
                               input frt_result_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("mismatch (%s) at %0t ns", what, $time);
      $display("  expected status=%0d complete=%0d bytes=%0d span=%0d",
               want.status, want.complete, want.byte_total, want.span);
      $display("  actual   status=%0d complete=%0d bytes=%0d span=%0d",
               got.status, got.complete, got.byte_total, got.span);
    end
  endtask

  // beat watch: everything is sampled on the rising edge, before the block updates
  always @(posedge clk) begin : beat_watch
    frt_result_t got;
    frt_result_t want;
    frt_result_t guess;
    bit          moved;
    moved = 1'b0;
    if (!rst) begin
      // report beats first: a fragment taken on this edge cannot report on it
      if (result_valid && !result_stall) begin
        moved          = 1'b1;
        got.status     = status;
        got.complete   = complete;
        got.byte_total = byte_total;
        got.span       = span;
        if (pending_reports.size() == 0) begin
          flag_mismatch("report beat with nothing owed", NO_REPORT, got);
        end else begin
          want = pending_reports.pop_front();
          if (got.status !== want.status || got.complete !== want.complete ||
              got.byte_total !== want.byte_total || got.span !== want.span)
            flag_mismatch("report fields", want, got);
        end
      end
      if (frag_valid && !frag_stall) begin
        moved = 1'b1;
        guess = track_fragment(frag_index, frag_length, is_last);
        pending_reports.push_back(typed_valid ? typed_report : guess);
      end
    end
    // watchdog on cycles with no beat on either channel
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // puts one fragment beat on the input, holds it until taken, then maybe idles
  task automatic offer_fragment(input logic [INDEX_W-1:0]  idx,
                                input logic [LENGTH_W-1:0] len,
                                input logic                last,
                                input logic                typed,
                                input frt_result_t         rep);
    int gap;
    frag_index   = idx;
    frag_length  = len;
    is_last      = last;
    typed_valid  = typed;
    typed_report = rep;
    frag_valid   = 1'b1;
    do @(posedge clk); while (frag_stall);
    @(negedge clk);
    // sender gaps, but never during the long hold-off so the block fills up
    if (!calm && !squeeze_on && $urandom_range(0, 5) == 0) begin
      gap        = $urandom_range(1, 13);
      frag_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // report side: random stall bursts, one long hold-off, none in the tail
  initial begin : report_sink
    int burst;
    result_stall = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (squeeze_req) begin
        squeeze_req  = 1'b0;
        squeeze_on   = 1'b1;
        result_stall = 1'b1;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
        squeeze_on   = 1'b0;
        result_stall = 1'b0;
        @(negedge clk);
      end else if (calm) begin
        result_stall = 1'b0;
        @(negedge clk);
      end else begin
        burst        = $urandom_range(1, 13);
        result_stall = ($urandom_range(0, 3) == 0);
        repeat (burst) @(negedge clk);
      end
    end
  end

  // fragment side: reset, directed script, then random fragments of the one message
  initial begin : fragment_source
    int                  slot;
    logic [INDEX_W-1:0]  idx;
    logic [LENGTH_W-1:0] len;
    logic                last;
    rst          = 1'b1;
    frag_valid   = 1'b0;
    frag_index   = '0;
    frag_length  = '0;
    is_last      = 1'b0;
    typed_valid  = 1'b0;
    typed_report = NO_REPORT;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (script[r])
      offer_fragment(script[r].idx, script[r].len, script[r].last,
                     script[r].typed, script[r].rep);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      calm = (n >= RANDOM_BEATS - CALM_BEATS);
      if (n == SQUEEZE_AT) squeeze_req = 1'b1;
      // mostly uniform slots; now and then the highest open one, which may close the message
      slot = top_open_slot();
      if (slot >= 0 && $urandom_range(0, 9) == 0)
        idx = INDEX_W'(slot);
      else
        idx = INDEX_W'($urandom_range(0, MAP_DEPTH - 1));
      case ($urandom_range(0, 15))
        0:       len = '0;
        1:       len = LEN_MAX;
        default: len = LENGTH_W'($urandom_range(0, MAX_FRAGMENT_LENGTH));
      endcase
      // a last flag that gets accepted only ever lands on the highest open slot,
      // so every slot below the span can still be filled and complete can rise
      last = 1'b0;
      if ((seen_map[idx] || int'(idx) == slot) && $urandom_range(0, 3) == 0)
        last = 1'b1;
      offer_fragment(idx, len, last, 1'b0, NO_REPORT);
    end
    frag_valid = 1'b0;

    // wait out the owed reports, then keep watching for stray beats
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/frt_pkg.sv
design/frt_tracker.sv
design/fragment_reassembly_tracker_core.sv
sim/testbench.sv
